[hw/rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the clock page replacement block
// Holds the controller state type, the command and status words that pass
// between the controller and the datapath, and fixed field widths.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Fixed widths of the configuration and result fields.
  localparam int CFG_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_NORM,
    ST_SWEEP,
    ST_EVICT_WB
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the page and rewind the scan pointer
    logic search_issue;  // read the frame at the scan pointer
    logic commit_hit;    // page found: set its reference bit
    logic commit_fill;   // miss with a free frame: fill it
    logic norm_step;     // bring the hand back into the managed range
    logic sweep_clear;   // clear the reference bit under the hand and advance
    logic evict_read;    // read the victim frame under the hand
    logic commit_evict;  // replace the victim and count the fault
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;      // the frame read last cycle holds the page
    logic scan_end;   // every resident frame has been issued for reading
    logic pending;    // a search read is still in flight
    logic full;       // every managed frame is filled
    logic hand_over;  // the hand sits at or beyond the managed range
    logic hand_ref;   // reference bit of the frame under the hand
  } status_t;

endpackage

[hw/rtl/cpr_ram.sv]
// ----------------------------------------------------------------------------
// cpr_ram: generic RAM with one write port and one registered read port
// Stores DEPTH words of WIDTH bits; read data is registered and appears in the
// cycle after the read enable.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl: controller for the clock page replacement block
// Sequences the frame search, the hand normalization, the reference-bit
// sweep and the final update of each page reference.
// ----------------------------------------------------------------------------
module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.match) begin
          state_next = ST_IDLE;
        end else if (status.scan_end && !status.pending) begin
          state_next = status.full ? ST_NORM : ST_IDLE;
        end
      end
      ST_NORM: begin
        if (!status.hand_over) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!status.hand_ref) state_next = ST_EVICT_WB;
      end
      ST_EVICT_WB: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SEARCH: begin
        cmd.commit_hit   = status.match;
        cmd.search_issue = !status.match && !status.scan_end;
        cmd.commit_fill  = !status.match && status.scan_end && !status.pending &&
                           !status.full;
      end
      ST_NORM: begin
        cmd.norm_step = status.hand_over;
      end
      ST_SWEEP: begin
        cmd.sweep_clear = status.hand_ref;
        cmd.evict_read  = !status.hand_ref;
      end
      ST_EVICT_WB: begin
        cmd.commit_evict = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // At most one kind of update finishes a reference.
  a_one_commit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.commit_hit, cmd.commit_fill, cmd.commit_evict}))
    else $error("more than one commit in a cycle");

  // Every commit hands the block back to idle.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_hit || cmd.commit_fill || cmd.commit_evict) |=> state == ST_IDLE)
    else $error("controller not idle after a commit");

  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("controller not busy after accepting a word");

endmodule

[hw/rtl/cpr_datapath.sv]
// ----------------------------------------------------------------------------
// cpr_datapath: frame store, reference bits, clock hand and counters
// Holds the page RAM, the per-frame reference bits, the fill count, the
// clock hand, the fault counter, the frame-count register and the result
// word registers.
// ----------------------------------------------------------------------------
module cpr_datapath
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     frames_in_use,
  input  logic [PAGE_BITS-1:0] page_number,
  output logic                 done,
  output logic                 hit,
  output logic                 fault,
  output logic [SLOT_W-1:0]    frame_slot,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [COUNT_W-1:0]   fault_total
);

  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int RESET_N = (FRAMES < 8) ? FRAMES : 8;

  logic [CNT_W-1:0]     frames_n;
  logic [CNT_W-1:0]     filled;
  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     scan;
  logic [IDX_W-1:0]     hand;
  logic [IDX_W-1:0]     rd_idx;
  logic                 pending;
  logic [FRAMES-1:0]    ref_bits;
  logic [COUNT_W-1:0]   fault_count;
  logic [COUNT_W-1:0]   fault_count_next;
  logic [PAGE_BITS-1:0] page;
  logic [PAGE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     fill_slot;
  logic [IDX_W-1:0]     fill_hand;
  logic [IDX_W-1:0]     hand_step;
  logic [CNT_W-1:0]     hand_wide;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [CNT_W-1:0]     cfg_limited;

  // Frames in play: the fill count, capped by the managed frame count.
  assign used      = (filled < frames_n) ? filled : frames_n;
  assign fill_slot = used[IDX_W-1:0];
  assign hand_wide = CNT_W'(hand);

  // Hand advance with wrap at the managed frame count.
  assign fill_hand = (used + CNT_W'(1) == frames_n) ? '0 : IDX_W'(used + CNT_W'(1));
  assign hand_step = (hand_wide + CNT_W'(1) == frames_n) ? '0 :
                     IDX_W'(hand_wide + CNT_W'(1));

  // Saturating fault count.
  assign fault_count_next = (fault_count == '1) ? fault_count : fault_count + COUNT_W'(1);

  // Written frame count clamped to one through FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      cfg_limited = CNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      cfg_limited = CNT_W'(FRAMES);
    end else begin
      cfg_limited = CNT_W'(frames_in_use);
    end
  end

  // Status toward the controller.
  assign status.match     = pending && (rd_data == page);
  assign status.scan_end  = (scan == used);
  assign status.pending   = pending;
  assign status.full      = (used == frames_n);
  assign status.hand_over = (hand_wide >= frames_n);
  assign status.hand_ref  = ref_bits[hand];

  // Page RAM ports: search and victim reads, fill and replace writes.
  assign ram_re    = cmd.search_issue || cmd.evict_read;
  assign ram_raddr = cmd.search_issue ? scan[IDX_W-1:0] : hand;
  assign ram_we    = cmd.commit_fill || cmd.commit_evict;
  assign ram_waddr = cmd.commit_fill ? fill_slot : hand;

  cpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (page),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  // Control state: frame count, scan, hand, reference bits, counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_n    <= CNT_W'(RESET_N);
      filled      <= '0;
      scan        <= '0;
      hand        <= '0;
      pending     <= 1'b0;
      ref_bits    <= '0;
      fault_count <= '0;
      done        <= 1'b0;
    end else begin
      done    <= cmd.commit_hit || cmd.commit_fill || cmd.commit_evict;
      pending <= cmd.search_issue;
      if (cfg_write) begin
        frames_n <= cfg_limited;
      end
      if (cmd.load) begin
        scan <= '0;
      end else if (cmd.search_issue) begin
        scan <= scan + CNT_W'(1);
      end
      if (cmd.commit_hit) begin
        ref_bits[rd_idx] <= 1'b1;
      end
      if (cmd.commit_fill) begin
        ref_bits[fill_slot] <= 1'b1;
        filled              <= used + CNT_W'(1);
        hand                <= fill_hand;
      end
      if (cmd.norm_step) begin
        hand <= IDX_W'(hand_wide - frames_n);
      end
      if (cmd.sweep_clear) begin
        ref_bits[hand] <= 1'b0;
        hand           <= hand_step;
      end
      if (cmd.commit_evict) begin
        ref_bits[hand] <= 1'b1;
        hand           <= hand_step;
        fault_count    <= fault_count_next;
      end
    end
  end

  // Payload: the current page, the index of the read in flight, the result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= page_number;
    end
    if (cmd.search_issue) begin
      rd_idx <= scan[IDX_W-1:0];
    end
    if (cmd.commit_hit) begin
      hit           <= 1'b1;
      fault         <= 1'b0;
      frame_slot    <= SLOT_W'(rd_idx);
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      fault_total   <= fault_count;
    end else if (cmd.commit_fill) begin
      hit           <= 1'b0;
      fault         <= 1'b0;
      frame_slot    <= SLOT_W'(fill_slot);
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      fault_total   <= fault_count;
    end else if (cmd.commit_evict) begin
      hit           <= 1'b0;
      fault         <= 1'b1;
      frame_slot    <= SLOT_W'(hand);
      evicted_valid <= 1'b1;
      evicted_page  <= rd_data;
      fault_total   <= fault_count_next;
    end
  end

  // The fault counter never runs backward.
  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> fault_count >= $past(fault_count))
    else $error("fault count decreased");

  // Only a replacement moves the fault counter.
  a_fault_only_evict: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit_evict) |-> fault_count == $past(fault_count))
    else $error("fault count changed without a replacement");

  // The fill count never passes the built frame count.
  a_filled_range: assert property (@(posedge clk) disable iff (rst)
    filled <= CNT_W'(FRAMES))
    else $error("fill count beyond frame store");

endmodule

[hw/rtl/clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement: second-chance (clock) page replacement engine
// Takes one page reference per word and reports hit, fault, the frame that
// holds the page, the evicted page and the running fault total.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   --------  ----------------------  ---------------------------------------
//   request   start, busy             page_number
//   result    done (one-cycle strobe) hit, fault, frame_slot, evicted_valid,
//                                     evicted_page, fault_total
//   config    cfg_write               frames_in_use
//
// A word is taken when start is high and busy is low. A hit or a fill is
// settled by the one-frame-per-cycle search of the page RAM, and a
// replacement also runs the one-frame-per-cycle sweep of the clock hand.
// After frames_in_use is lowered, the first replacement first steps the hand
// back into range by n, the managed frame count, at a time. A new word may
// start in the cycle that done is shown. Reset clears all frames; the
// result side cannot stall, so done is shown once and must be taken.
// ----------------------------------------------------------------------------
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page_number,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     frames_in_use,
  output logic                 done,
  output logic                 hit,
  output logic                 fault,
  output logic [SLOT_W-1:0]    frame_slot,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [COUNT_W-1:0]   fault_total
);

  cmd_t    cmd;
  status_t status;

  // Controller: sequences search, sweep and update.
  cpr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: frame store, hand, reference bits and result word.
  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .frames_in_use (frames_in_use),
    .page_number   (page_number),
    .done          (done),
    .hit           (hit),
    .fault         (fault),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule
